// File: sv/terminal_key_escape_decoder_assert.svh
`ifndef TERMINAL_KEY_ESCAPE_DECODER_ASSERT_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KED_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ked assertion failed");

// Next-cycle implication, disabled while reset is held.
`define KED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ked assertion failed");

`endif

// File: sv/ked_pkg.sv
package ked_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } ked_in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [20:0] code_point;
    logic [4:0]  key_code;
    logic [2:0]  modifiers;
  } ked_out_t;

  // request types
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_WAIT = 2'd1;
  localparam logic [1:0] REQ_EOS  = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // event kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_EOS  = 2'd2;
  localparam logic [1:0] KIND_NULL = 2'd3;

  // key codes
  localparam logic [4:0] K_ESC   = 5'd0;
  localparam logic [4:0] K_UP    = 5'd1;
  localparam logic [4:0] K_DOWN  = 5'd2;
  localparam logic [4:0] K_LEFT  = 5'd3;
  localparam logic [4:0] K_RIGHT = 5'd4;
  localparam logic [4:0] K_HOME  = 5'd5;
  localparam logic [4:0] K_END   = 5'd6;
  localparam logic [4:0] K_INS   = 5'd7;
  localparam logic [4:0] K_DEL   = 5'd8;
  localparam logic [4:0] K_PGUP  = 5'd9;
  localparam logic [4:0] K_PGDN  = 5'd10;
  localparam logic [4:0] K_F1    = 5'd11;

endpackage

// File: sv/terminal_key_escape_decoder.sv
// An item waits in the input register; its result (if any) is registered for out_valid.
// Throughput: one item per cycle while out_stall does not hold a full result stage.
// A held result stalls the input register only when both stages are full.
// Reset (rst_n low, synchronous): parser idle, UTF-8 assembly off, both stages empty.
module terminal_key_escape_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ked_pkg::ked_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output ked_pkg::ked_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import ked_pkg::*;
  `include "terminal_key_escape_decoder_assert.svh"

  // Input register stage
  logic     in_vld_r;
  ked_in_t  in_r;

  // Result register stage
  logic     out_vld_r;
  ked_out_t out_r;

  // Configuration
  logic     utf8_en_r;

  logic     out_free;
  logic     advance;
  logic     res_valid;
  ked_out_t res;

  // Output slot can take a new result when empty or being drained this cycle.
  assign out_free  = !out_vld_r || !out_stall;
  // The held input item is decoded (and the parser state stepped) only then.
  assign advance   = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      utf8_en_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= advance && res_valid;
      end
      if (cfg_valid && cfg_ready) begin
        utf8_en_r <= cfg_data;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_item;
    end
    if (out_free) begin
      out_r <= res;
    end
  end

  ked_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .item        (in_r),
    .utf8_enable (utf8_en_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // A blocked input item stays in place until decoded.
  `KED_ASSERT_NEXT(a_in_hold, clk, rst_n, in_vld_r && !advance, in_vld_r)
  // Only character results carry a code point.
  `KED_ASSERT_NOW(a_cp_char, clk, rst_n,
    out_vld_r && out_r.event_kind != KIND_CHAR, out_r.code_point == 21'd0)
  // Key code is zero unless a special key is reported.
  `KED_ASSERT_NOW(a_key_kind, clk, rst_n,
    out_vld_r && out_r.event_kind != KIND_KEY, out_r.key_code == K_ESC)
  // Modifiers only come with key or null-key results.
  `KED_ASSERT_NOW(a_mod_kind, clk, rst_n, out_vld_r && out_r.modifiers != 3'd0,
    out_r.event_kind == KIND_KEY || out_r.event_kind == KIND_NULL)

endmodule

// File: sv/ked_core.sv
module ked_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  ked_pkg::ked_in_t  item,
  input  logic              utf8_enable,
  output logic              res_valid,
  output ked_pkg::ked_out_t res
);
  import ked_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ESC, ST_SS3, ST_CSI, ST_CSI2, ST_NUM, ST_MOD, ST_FINAL, ST_UTF8
  } ked_state_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] key;
  } key_hit_t;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [9:0] NUM_MAX  = 10'd1023;

  function automatic key_hit_t letter_key(input logic [7:0] b);
    key_hit_t h;
    h = '{ok: 1'b1, key: K_ESC};
    unique case (b)
      CH_A:    h.key = K_UP;
      CH_B:    h.key = K_DOWN;
      CH_C:    h.key = K_RIGHT;
      CH_D:    h.key = K_LEFT;
      CH_H:    h.key = K_HOME;
      CH_F:    h.key = K_END;
      default: h.ok  = 1'b0;
    endcase
    return h;
  endfunction

  function automatic key_hit_t tilde_key(input logic [9:0] n);
    key_hit_t h;
    h = '{ok: 1'b1, key: K_ESC};
    unique case (n)
      10'd1, 10'd7:  h.key = K_HOME;
      10'd4, 10'd8:  h.key = K_END;
      10'd2:         h.key = K_INS;
      10'd3:         h.key = K_DEL;
      10'd5:         h.key = K_PGUP;
      10'd6:         h.key = K_PGDN;
      10'd11, 10'd12, 10'd13, 10'd14, 10'd15:
        h.key = K_F1 + 5'(n - 10'd11);
      10'd17, 10'd18, 10'd19, 10'd20, 10'd21:
        h.key = K_F1 + 5'd5 + 5'(n - 10'd17);
      10'd23, 10'd24:
        h.key = K_F1 + 5'd10 + 5'(n - 10'd23);
      default:       h.ok = 1'b0;
    endcase
    return h;
  endfunction

  function automatic key_hit_t z_key(input logic [9:0] n);
    key_hit_t h;
    h = '{ok: 1'b0, key: K_ESC};
    if (n >= 10'd224 && n <= 10'd233) begin
      h.ok  = 1'b1;
      h.key = K_F1 + 5'(n - 10'd224);
    end else if (n == 10'd192 || n == 10'd193) begin
      h.ok  = 1'b1;
      h.key = K_F1 + 5'd10 + 5'(n - 10'd192);
    end
    return h;
  endfunction

  ked_state_t  state_r, state_nxt;
  logic [9:0]  num_r, num_nxt;
  logic [4:0]  pend_key_r, pend_key_nxt;
  logic        pend_is_key_r, pend_is_key_nxt;
  logic [2:0]  mods_r, mods_nxt;
  logic [20:0] u8_val_r, u8_val_nxt;
  logic [1:0]  u8_rem_r, u8_rem_nxt;

  logic        clear;
  logic [7:0]  b;
  logic [13:0] num_prod;
  logic [20:0] u8_shift;
  logic [1:0]  u8_dec;
  key_hit_t    hit;

  assign b        = item.data_byte;
  assign num_prod = 14'(num_r) * 14'd10 + 14'(b - CH_0);
  assign u8_shift = {u8_val_r[14:0], b[5:0]};
  assign u8_dec   = u8_rem_r - 2'd1;

  always_comb begin
    state_nxt       = state_r;
    num_nxt         = num_r;
    pend_key_nxt    = pend_key_r;
    pend_is_key_nxt = pend_is_key_r;
    mods_nxt        = mods_r;
    u8_val_nxt      = u8_val_r;
    u8_rem_nxt      = u8_rem_r;
    clear           = 1'b0;
    res_valid       = 1'b0;
    res             = '0;
    hit             = '{ok: 1'b0, key: K_ESC};

    unique case (item.req_type)
      REQ_NONE: ;
      REQ_WAIT: begin
        if (state_r != ST_IDLE && state_r != ST_UTF8) begin
          clear          = 1'b1;
          res_valid      = 1'b1;
          res.event_kind = KIND_KEY;
          res.key_code   = K_ESC;
        end
      end
      REQ_EOS: begin
        clear          = 1'b1;
        res_valid      = 1'b1;
        res.event_kind = (state_r == ST_ESC) ? KIND_KEY : KIND_EOS;
      end
      REQ_BYTE: begin
        unique case (state_r)
          ST_IDLE: begin
            if (b == CH_ESC) begin
              state_nxt = ST_ESC;
            end else if (utf8_enable && b[7:5] == 3'b110) begin
              u8_val_nxt = 21'(b[4:0]);
              u8_rem_nxt = 2'd1;
              state_nxt  = ST_UTF8;
            end else if (utf8_enable && b[7:4] == 4'b1110) begin
              u8_val_nxt = 21'(b[3:0]);
              u8_rem_nxt = 2'd2;
              state_nxt  = ST_UTF8;
            end else if (utf8_enable && b[7:3] == 5'b11110) begin
              u8_val_nxt = 21'(b[2:0]);
              u8_rem_nxt = 2'd3;
              state_nxt  = ST_UTF8;
            end else begin
              res_valid      = 1'b1;
              res.event_kind = KIND_CHAR;
              res.code_point = 21'(b);
            end
          end
          ST_UTF8: begin
            u8_val_nxt = u8_shift;
            u8_rem_nxt = u8_dec;
            if (u8_dec == 2'd0) begin
              clear          = 1'b1;
              res_valid      = 1'b1;
              res.event_kind = KIND_CHAR;
              res.code_point = u8_shift;
            end
          end
          ST_ESC: begin
            if (b == CH_O) begin
              state_nxt = ST_SS3;
            end else if (b == CH_LBRK) begin
              state_nxt = ST_CSI;
            end else begin
              clear          = 1'b1;
              res_valid      = 1'b1;
              res.event_kind = KIND_NULL;
            end
          end
          ST_SS3: begin
            hit.ok  = (b >= CH_P && b <= CH_S);
            hit.key = K_F1 + 5'(b - CH_P);
            clear     = 1'b1;
            res_valid = 1'b1;
          end
          ST_CSI: begin
            if (b == CH_LBRK) begin
              state_nxt = ST_CSI2;
            end else if (b >= CH_1 && b <= CH_9) begin
              num_nxt   = 10'(b - CH_0);
              state_nxt = ST_NUM;
            end else begin
              hit       = letter_key(b);
              clear     = 1'b1;
              res_valid = 1'b1;
            end
          end
          ST_CSI2: begin
            hit.ok  = (b >= CH_A && b <= CH_E);
            hit.key = K_F1 + 5'(b - CH_A);
            clear     = 1'b1;
            res_valid = 1'b1;
          end
          ST_NUM: begin
            if (b >= CH_0 && b <= CH_9) begin
              num_nxt = (num_prod > 14'(NUM_MAX)) ? NUM_MAX : num_prod[9:0];
            end else if (b == CH_SEMI) begin
              hit             = tilde_key(num_r);
              pend_is_key_nxt = hit.ok;
              pend_key_nxt    = hit.ok ? hit.key : K_ESC;
              state_nxt       = ST_MOD;
            end else begin
              if (b == CH_Z) begin
                hit = z_key(num_r);
              end else if (b == CH_TILDE) begin
                hit = tilde_key(num_r);
              end
              clear     = 1'b1;
              res_valid = 1'b1;
            end
          end
          ST_MOD: begin
            mods_nxt  = (b >= CH_2 && b <= CH_8) ? 3'(b - CH_1) : 3'd0;
            state_nxt = ST_FINAL;
          end
          ST_FINAL: begin
            hit = letter_key(b);
            if (!hit.ok && pend_is_key_r) begin
              hit = '{ok: 1'b1, key: pend_key_r};
            end
            res.modifiers = mods_r;
            clear         = 1'b1;
            res_valid     = 1'b1;
          end
          default: clear = 1'b1;
        endcase
        // key-or-null result for the escape-sequence states
        if (res_valid && state_r != ST_IDLE && state_r != ST_UTF8 &&
            state_r != ST_ESC) begin
          res.event_kind = hit.ok ? KIND_KEY : KIND_NULL;
          res.key_code   = hit.ok ? hit.key : K_ESC;
        end
      end
      default: ;
    endcase

    if (clear) begin
      state_nxt       = ST_IDLE;
      num_nxt         = '0;
      pend_key_nxt    = '0;
      pend_is_key_nxt = 1'b0;
      mods_nxt        = '0;
      u8_val_nxt      = '0;
      u8_rem_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      num_r         <= '0;
      pend_key_r    <= '0;
      pend_is_key_r <= 1'b0;
      mods_r        <= '0;
      u8_val_r      <= '0;
      u8_rem_r      <= '0;
    end else if (step_en) begin
      state_r       <= state_nxt;
      num_r         <= num_nxt;
      pend_key_r    <= pend_key_nxt;
      pend_is_key_r <= pend_is_key_nxt;
      mods_r        <= mods_nxt;
      u8_val_r      <= u8_val_nxt;
      u8_rem_r      <= u8_rem_nxt;
    end
  end

endmodule
